// ----- design/scpg_pkg.sv -----
// Shared constants, register codes and sine table functions of the curve point generator.
// Depends on nothing; the top level takes everything here by scoped names.
`default_nettype none

package scpg_pkg;

    // Default sizes of the screen and of the sine table.
    localparam int WIDTH_DEF       = 640;
    localparam int HEIGHT_DEF      = 480;
    localparam int SINE_DEPTH_DEF  = 1024;

    // Field widths.
    localparam int ANGLE_W   = 16;
    localparam int X_POS_W   = 10;
    localparam int Y_POS_W   = 9;
    localparam int FREQ_W    = 13;
    localparam int PRIME_W   = 5;
    localparam int MIX_W     = 4;
    localparam int SINE_W    = 16;
    localparam int PF_W      = FREQ_W + PRIME_W;
    localparam int SUM_W     = 20;
    localparam int NUM_W     = 27;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_M  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_N  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_J = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_K = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_L = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX     = 3'd6;

    localparam logic [FREQ_W-1:0]  FREQ_RST  = 13'd256;
    localparam logic [PRIME_W-1:0] PRIME_RST = 5'd2;
    localparam logic [MIX_W-1:0]   MIX_RST   = 4'd10;
    localparam logic [MIX_W-1:0]   MIX_MIN   = 4'd1;
    localparam logic [MIX_W-1:0]   MIX_MAX   = 4'd10;

    // Quarter turn added to a sine argument to read the cosine.
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

    // Divisor 2.2 scaled by 1000 * 32768 is 1100 * 2^16; offset 0.47 times it is 47 * 720896.
    localparam int MIX_OFFSET  = 33882112;
    localparam int MIX_SCALE   = 100;
    localparam int DIV_SHIFT   = 16;
    // ceil(2^32 / 1100); exact floor division for dividends below 2^23.
    localparam int RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP_1100 = 22'd3904516;
    localparam int RECIP_SHIFT = 32;

    // Q30 constants for building the sine table.
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    // sin(x) in Q30 for x in [0, pi/2], Horner form truncated at every step.
    function automatic longint unsigned quarter_sine(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    // One Q1.15 table entry: rounded half up, clamped, negated in the lower half wave.
    function automatic logic signed [SINE_W-1:0] sine_entry(input logic neg,
                                                             input longint unsigned x);
        longint unsigned s;
        longint unsigned e;
        logic [SINE_W-1:0] mag;
        s = quarter_sine(x);
        e = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (e > 64'd32767)
        begin
            e = 64'd32767;
        end
        mag = SINE_W'(e);
        return neg ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

// ----- design/sinusoid_curve_point_generator.sv -----
// Top level of the curve point generator: an eight-stage pipeline with two sine ROM copies.
// Depends on scpg_pkg for field widths, register codes, constants and the sine table entries.
`default_nettype none

// Usage.
// The slave stream takes one request per point: angle in the low half of s_axis_tdata and
// phase in the high half, both unsigned fractions of one turn. The master stream returns
// the pixel point, x_pos in the low bits and y_pos above it. Every request gives exactly
// one point, in order.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the two frequencies, the four
// primes and the mix; write it only while no request is in flight.
// Throughput is one point per clock unless the receiver stalls. Each request passes the
// stages in order: stage one holds the request, stage two forms the four prime * freq *
// angle products, stage three adds phase and scales to a table index, stage four reads the
// sine ROMs, stage five mixes, stage six adds the offset, stage seven scales by the screen
// size and stage eight divides by 1100 through a reciprocal multiply.
// Each stage holds a valid bit and advances whenever it is empty or the stage after it
// advances, so a stalled receiver backs the pipeline up one stage at a time while bubbles
// are still filled; nothing is lost or repeated.
// Reset empties the pipeline and returns the registers to freq 1.0, primes 2 and a mix of
// ten tenths. The sine table is constant and needs no clearing pass.

module sinusoid_curve_point_generator #(
    parameter int WIDTH            = scpg_pkg::WIDTH_DEF,
    parameter int HEIGHT           = scpg_pkg::HEIGHT_DEF,
    parameter int SINE_TABLE_DEPTH = scpg_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [scpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [scpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Request stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [scpg_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // angle[15:0], phase[31:16]
    // Point stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [scpg_pkg::OUT_DATA_W-1:0]         m_axis_tdata    // x_pos[9:0], y_pos[18:10]
);

    localparam int NSTG   = 8;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int DW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int XSW    = $clog2(WIDTH + 1);
    localparam int YSW    = $clog2(HEIGHT + 1);
    localparam int XT_W   = XSW + scpg_pkg::NUM_W - scpg_pkg::DIV_SHIFT;
    localparam int YT_W   = YSW + scpg_pkg::NUM_W - scpg_pkg::DIV_SHIFT;
    localparam int AW     = scpg_pkg::ANGLE_W;
    localparam int SW     = scpg_pkg::SINE_W;
    localparam int PW     = scpg_pkg::PF_W;
    localparam int NW     = scpg_pkg::NUM_W;
    localparam int PAD_W  = scpg_pkg::OUT_DATA_W - scpg_pkg::X_POS_W - scpg_pkg::Y_POS_W;
    localparam longint unsigned DEPTH_L = longint'(SINE_TABLE_DEPTH);
    localparam logic [DW-1:0] DEPTH_C = DW'(SINE_TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers and the values derived from them.
    // ------------------------------------------------------------------
    logic [scpg_pkg::FREQ_W-1:0]  freq_m_reg, freq_n_reg;
    logic [scpg_pkg::PRIME_W-1:0] prime_i_reg, prime_j_reg, prime_k_reg, prime_l_reg;
    logic [scpg_pkg::MIX_W-1:0]   mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_m_reg  <= scpg_pkg::FREQ_RST;
            freq_n_reg  <= scpg_pkg::FREQ_RST;
            prime_i_reg <= scpg_pkg::PRIME_RST;
            prime_j_reg <= scpg_pkg::PRIME_RST;
            prime_k_reg <= scpg_pkg::PRIME_RST;
            prime_l_reg <= scpg_pkg::PRIME_RST;
            mix_reg     <= scpg_pkg::MIX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scpg_pkg::CFG_FREQ_M:  freq_m_reg  <= cfg_data[scpg_pkg::FREQ_W-1:0];
                scpg_pkg::CFG_FREQ_N:  freq_n_reg  <= cfg_data[scpg_pkg::FREQ_W-1:0];
                scpg_pkg::CFG_PRIME_I: prime_i_reg <= cfg_data[scpg_pkg::PRIME_W-1:0];
                scpg_pkg::CFG_PRIME_J: prime_j_reg <= cfg_data[scpg_pkg::PRIME_W-1:0];
                scpg_pkg::CFG_PRIME_K: prime_k_reg <= cfg_data[scpg_pkg::PRIME_W-1:0];
                scpg_pkg::CFG_PRIME_L: prime_l_reg <= cfg_data[scpg_pkg::PRIME_W-1:0];
                scpg_pkg::CFG_MIX:     mix_reg     <= cfg_data[scpg_pkg::MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-argument step size prime * freq, order: x first, x second, y first, y second.
    // The mix is clamped to one through ten tenths. These are registered from the config
    // registers, ready before a request sent after a write reaches the stages that use them.
    logic [PW-1:0]                pf_next [4];
    logic [PW-1:0]                pf_reg  [4];
    logic [scpg_pkg::MIX_W-1:0]   mix_r_next, mix_rc_next, mix_r_reg, mix_rc_reg;

    always_comb
    begin
        pf_next[0] = PW'(prime_i_reg) * PW'(freq_m_reg);
        pf_next[1] = PW'(prime_k_reg) * PW'(freq_n_reg);
        pf_next[2] = PW'(prime_j_reg) * PW'(freq_m_reg);
        pf_next[3] = PW'(prime_l_reg) * PW'(freq_n_reg);
        if (mix_reg < scpg_pkg::MIX_MIN)
        begin
            mix_r_next = scpg_pkg::MIX_MIN;
        end
        else if (mix_reg > scpg_pkg::MIX_MAX)
        begin
            mix_r_next = scpg_pkg::MIX_MAX;
        end
        else
        begin
            mix_r_next = mix_reg;
        end
        mix_rc_next = scpg_pkg::MIX_MAX - mix_r_next;
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 4; n++)
        begin
            pf_reg[n] <= pf_next[n];
        end
        mix_r_reg  <= mix_r_next;
        mix_rc_reg <= mix_rc_next;
    end

    // ------------------------------------------------------------------
    // Sine table, built at elaboration. Two copies give four reads per cycle.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sine_rom_x [SINE_TABLE_DEPTH];
    logic signed [SW-1:0] sine_rom_y [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_rom
        localparam longint unsigned K4  = 64'd4 * k;
        localparam longint unsigned QK  = K4 / DEPTH_L;
        localparam longint unsigned RK  = K4 - QK * DEPTH_L;
        localparam longint unsigned XR  = RK * scpg_pkg::Q30_HALF_PI / DEPTH_L;
        localparam longint unsigned XQ  = (QK == 64'd1 || QK == 64'd3) ?
                                          scpg_pkg::Q30_HALF_PI - XR : XR;
        localparam logic signed [SW-1:0] ENTRY = scpg_pkg::sine_entry(QK >= 64'd2, XQ);
        assign sine_rom_x[k] = ENTRY;
        assign sine_rom_y[k] = ENTRY;
    end

    // ------------------------------------------------------------------
    // Pipeline flow control.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg, vld_next, adv;

    always_comb
    begin
        adv[NSTG-1] = ~vld_reg[NSTG-1] | m_axis_tready;
        for (int s = NSTG - 2; s >= 0; s--)
        begin
            adv[s] = ~vld_reg[s] | adv[s+1];
        end
        vld_next[0] = adv[0] ? s_axis_tvalid : vld_reg[0];
        for (int s = 1; s < NSTG; s++)
        begin
            vld_next[s] = adv[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 1: request register.
    // ------------------------------------------------------------------
    logic [AW-1:0] angle_reg, phase1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            angle_reg  <= s_axis_tdata[AW-1:0];
            phase1_reg <= s_axis_tdata[2*AW-1:AW];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: prime * freq * angle; bits 23..8 are the turn fraction.
    // ------------------------------------------------------------------
    logic [PW+AW-1:0] prod_full [4];
    logic [AW-1:0]    frac_next [4];
    logic [AW-1:0]    frac_reg  [4];
    logic [AW-1:0]    phase2_reg;

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            prod_full[n] = (PW+AW)'(pf_reg[n]) * (PW+AW)'(angle_reg);
            frac_next[n] = prod_full[n][AW+7:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int n = 0; n < 4; n++)
            begin
                frac_reg[n] <= frac_next[n];
            end
            phase2_reg <= phase1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add phase (and a quarter turn for the cosines), scale to a table index.
    // ------------------------------------------------------------------
    logic [AW-1:0]    arg_next  [4];
    logic [AW+DW-1:0] idx_full  [4];
    logic [IDX_W-1:0] idx_next  [4];
    logic [IDX_W-1:0] idx_reg   [4];

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            arg_next[n] = frac_reg[n] + phase2_reg
                        + ((n >= 2) ? scpg_pkg::QUARTER_TURN : '0);
            idx_full[n] = (AW+DW)'(arg_next[n]) * (AW+DW)'(DEPTH_C);
            idx_next[n] = idx_full[n][AW+IDX_W-1:AW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int n = 0; n < 4; n++)
            begin
                idx_reg[n] <= idx_next[n];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: ROM reads, x terms from one copy and y terms from the other.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sin_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sin_reg[0] <= sine_rom_x[idx_reg[0]];
            sin_reg[1] <= sine_rom_x[idx_reg[1]];
            sin_reg[2] <= sine_rom_y[idx_reg[2]];
            sin_reg[3] <= sine_rom_y[idx_reg[3]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: mix the two terms as r and ten minus r tenths.
    // ------------------------------------------------------------------
    localparam int SUMW = scpg_pkg::SUM_W;
    logic signed [scpg_pkg::MIX_W:0] r_s, rc_s;
    logic signed [SUMW-1:0]          xsum_next, ysum_next, xsum_reg, ysum_reg;

    always_comb
    begin
        r_s       = {1'b0, mix_r_reg};
        rc_s      = {1'b0, mix_rc_reg};
        xsum_next = SUMW'(r_s) * SUMW'(sin_reg[0]) + SUMW'(rc_s) * SUMW'(sin_reg[1]);
        ysum_next = SUMW'(r_s) * SUMW'(sin_reg[2]) + SUMW'(rc_s) * SUMW'(sin_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            xsum_reg <= xsum_next;
            ysum_reg <= ysum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: numerator 100 * sum + offset, always positive.
    // ------------------------------------------------------------------
    logic signed [NW:0] xnum_full, ynum_full;
    logic [NW-1:0]      xnum_next, ynum_next, xnum_reg, ynum_reg;

    always_comb
    begin
        xnum_full = (NW+1)'(scpg_pkg::MIX_OFFSET)
                  + (NW+1)'(scpg_pkg::MIX_SCALE) * (NW+1)'(xsum_reg);
        ynum_full = (NW+1)'(scpg_pkg::MIX_OFFSET)
                  + (NW+1)'(scpg_pkg::MIX_SCALE) * (NW+1)'(ysum_reg);
        xnum_next = xnum_full[NW-1:0];
        ynum_next = ynum_full[NW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            xnum_reg <= xnum_next;
            ynum_reg <= ynum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: scale by the screen size and drop the 2^16 part of the divisor.
    // ------------------------------------------------------------------
    logic [XSW+NW-1:0] xscl_full;
    logic [YSW+NW-1:0] yscl_full;
    logic [XT_W-1:0]   xt_next, xt_reg;
    logic [YT_W-1:0]   yt_next, yt_reg;

    always_comb
    begin
        xscl_full = (XSW+NW)'(WIDTH) * (XSW+NW)'(xnum_reg);
        yscl_full = (YSW+NW)'(HEIGHT) * (YSW+NW)'(ynum_reg);
        xt_next   = xscl_full[XSW+NW-1:scpg_pkg::DIV_SHIFT];
        yt_next   = yscl_full[YSW+NW-1:scpg_pkg::DIV_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            xt_reg <= xt_next;
            yt_reg <= yt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: divide by 1100 through the reciprocal and hold the point for the receiver.
    // ------------------------------------------------------------------
    localparam int XQ_W = XT_W + scpg_pkg::RECIP_W;
    localparam int YQ_W = YT_W + scpg_pkg::RECIP_W;
    logic [XQ_W-1:0]                 xq_full;
    logic [YQ_W-1:0]                 yq_full;
    logic [scpg_pkg::X_POS_W-1:0]    x_pos_next, x_pos_reg;
    logic [scpg_pkg::Y_POS_W-1:0]    y_pos_next, y_pos_reg;

    always_comb
    begin
        xq_full    = XQ_W'(xt_reg) * XQ_W'(scpg_pkg::RECIP_1100);
        yq_full    = YQ_W'(yt_reg) * YQ_W'(scpg_pkg::RECIP_1100);
        x_pos_next = scpg_pkg::X_POS_W'(xq_full >> scpg_pkg::RECIP_SHIFT);
        y_pos_next = scpg_pkg::Y_POS_W'(yq_full >> scpg_pkg::RECIP_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            x_pos_reg <= x_pos_next;
            y_pos_reg <= y_pos_next;
        end
    end

    assign m_axis_tdata = {PAD_W'(0), y_pos_reg, x_pos_reg};

endmodule

`default_nettype wire

// ----- tb/curve_point_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the curve point generator: follows the register writes, predicts each
// point from the accepted requests and compares it with the point stream, in order.
// Depends on scpg_pkg for field widths, register indexes and the scaling constants.

module curve_point_checker #(
    parameter int WIDTH            = scpg_pkg::WIDTH_DEF,
    parameter int HEIGHT           = scpg_pkg::HEIGHT_DEF,
    parameter int SINE_TABLE_DEPTH = scpg_pkg::SINE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scpg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [scpg_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // angle[15:0], phase[31:16]
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [scpg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // x_pos[9:0], y_pos[18:10]
    output int unsigned                         outstanding_points,
    output int unsigned                         point_errors
);

    import scpg_pkg::*;

    localparam int     FREQ_FRAC    = 8;
    localparam int     LUT_PEAK     = 32767;
    localparam longint COORD_DENOM  = 1100 * (1 << DIV_SHIFT);

    typedef struct packed {
        logic [X_POS_W-1:0] x_pos;
        logic [Y_POS_W-1:0] y_pos;
    } point_t;

    logic signed [SINE_W-1:0] sine_lut [SINE_TABLE_DEPTH];

    // Mirror of the configuration registers.
    logic [FREQ_W-1:0]  mul_a;
    logic [FREQ_W-1:0]  mul_b;
    logic [PRIME_W-1:0] fac_xa;
    logic [PRIME_W-1:0] fac_ya;
    logic [PRIME_W-1:0] fac_xb;
    logic [PRIME_W-1:0] fac_yb;
    logic [MIX_W-1:0]   weight;

    point_t      points_due [$];
    int unsigned fail_tally;

    // Sine over the first quarter wave in Q30, Taylor series to x^11 in Horner form,
    // truncated after every step.
    function automatic longint unsigned quarter_wave(input longint unsigned x);
        longint unsigned sq;
        longint unsigned acc;
        int unsigned     divisors [5];
        divisors = '{110, 72, 42, 20, 6};
        sq  = (x * x) >> 30;
        acc = Q30_ONE;
        foreach (divisors[i])
        begin
            acc = Q30_ONE - ((sq * acc) >> 30) / divisors[i];
        end
        return (x * acc) >> 30;
    endfunction

    initial
    begin : build_lut
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned mag;
        longint          val;
        for (longint unsigned k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            quad = (4 * k) / SINE_TABLE_DEPTH;
            rem  = 4 * k - quad * SINE_TABLE_DEPTH;
            x    = rem * Q30_HALF_PI / SINE_TABLE_DEPTH;
            // Second and fourth quarters run the quarter wave backwards.
            if (quad[0])
            begin
                x = Q30_HALF_PI - x;
            end
            mag = (quarter_wave(x) * LUT_PEAK + (Q30_ONE >> 1)) >> 30;
            if (mag > LUT_PEAK)
            begin
                mag = LUT_PEAK;
            end
            val = longint'(mag);
            if (quad >= 2)
            begin
                val = -val;
            end
            sine_lut[k] = val[SINE_W-1:0];
        end
    end

    function automatic longint lut_read(input logic [ANGLE_W-1:0] arg);
        longint unsigned idx;
        idx = (64'(arg) * SINE_TABLE_DEPTH) >> ANGLE_W;
        if (idx >= SINE_TABLE_DEPTH)
        begin
            idx = SINE_TABLE_DEPTH - 1;
        end
        return sine_lut[idx];
    endfunction

    // prime * freq * angle carries 24 fraction bits; keep one turn of it, then add phase.
    function automatic logic [ANGLE_W-1:0] turn_of(input logic [PRIME_W-1:0] fac,
                                                   input logic [FREQ_W-1:0]  mul,
                                                   input logic [ANGLE_W-1:0] ang,
                                                   input logic [ANGLE_W-1:0] ph);
        longint unsigned prod;
        prod = 64'(fac) * 64'(mul) * 64'(ang);
        return ANGLE_W'(prod >> FREQ_FRAC) + ph;
    endfunction

    // floor(extent * (0.47 + sum / (2.2 * 10 * 32768))) in exact integers.
    function automatic longint unsigned screen_coord(input longint sum, input int extent);
        longint num;
        num = longint'(MIX_OFFSET) + longint'(MIX_SCALE) * sum;
        return longint'(extent) * num / COORD_DENOM;
    endfunction

    function automatic point_t predict_point(input logic [ANGLE_W-1:0] ang,
                                             input logic [ANGLE_W-1:0] ph);
        longint w;
        longint rest;
        longint sx;
        longint sy;
        point_t pt;
        // Mix weights outside 1..10 are pinned to the nearest end.
        w = longint'(weight);
        if (w < longint'(MIX_MIN))
        begin
            w = longint'(MIX_MIN);
        end
        if (w > longint'(MIX_MAX))
        begin
            w = longint'(MIX_MAX);
        end
        rest = longint'(MIX_MAX) - w;
        sx = w * lut_read(turn_of(fac_xa, mul_a, ang, ph))
           + rest * lut_read(turn_of(fac_xb, mul_b, ang, ph));
        sy = w * lut_read(turn_of(fac_ya, mul_a, ang, ph) + QUARTER_TURN)
           + rest * lut_read(turn_of(fac_yb, mul_b, ang, ph) + QUARTER_TURN);
        pt.x_pos = X_POS_W'(screen_coord(sx, WIDTH));
        pt.y_pos = Y_POS_W'(screen_coord(sy, HEIGHT));
        return pt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t got;
        point_t want;
        if (!rst_n)
        begin
            mul_a  = FREQ_RST;
            mul_b  = FREQ_RST;
            fac_xa = PRIME_RST;
            fac_ya = PRIME_RST;
            fac_xb = PRIME_RST;
            fac_yb = PRIME_RST;
            weight = MIX_RST;
            points_due.delete();
            fail_tally = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FREQ_M:  mul_a  = cfg_data[FREQ_W-1:0];
                    CFG_FREQ_N:  mul_b  = cfg_data[FREQ_W-1:0];
                    CFG_PRIME_I: fac_xa = cfg_data[PRIME_W-1:0];
                    CFG_PRIME_J: fac_ya = cfg_data[PRIME_W-1:0];
                    CFG_PRIME_K: fac_xb = cfg_data[PRIME_W-1:0];
                    CFG_PRIME_L: fac_yb = cfg_data[PRIME_W-1:0];
                    CFG_MIX:     weight = cfg_data[MIX_W-1:0];
                    default:     ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                points_due.push_back(predict_point(s_axis_tdata[ANGLE_W-1:0],
                                                   s_axis_tdata[ANGLE_W +: ANGLE_W]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x_pos = m_axis_tdata[X_POS_W-1:0];
                got.y_pos = m_axis_tdata[X_POS_W +: Y_POS_W];
                if (points_due.size() == 0)
                begin
                    fail_tally++;
                    $display("%0t: point with no request: expected none, got x=%0d y=%0d",
                             $time, got.x_pos, got.y_pos);
                end
                else
                begin
                    want = points_due.pop_front();
                    if (got.x_pos !== want.x_pos)
                    begin
                        fail_tally++;
                        $display("%0t: x_pos mismatch: expected %0d, got %0d",
                                 $time, want.x_pos, got.x_pos);
                    end
                    if (got.y_pos !== want.y_pos)
                    begin
                        fail_tally++;
                        $display("%0t: y_pos mismatch: expected %0d, got %0d",
                                 $time, want.y_pos, got.y_pos);
                    end
                end
            end
        end
        outstanding_points <= points_due.size();
        point_errors       <= fail_tally;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the curve point generator testbench: clock, reset, register settings, requests
// and the receiver's stall pattern. Scoring is left to curve_point_checker.
// Depends on scpg_pkg, sinusoid_curve_point_generator and curve_point_checker.

module testbench;

    import scpg_pkg::*;

    localparam int     CLK_HALF_NS      = 4;
    localparam int     RESET_CYCLES     = 4;
    localparam int     PHASE_COUNT      = 12;
    localparam int     POINTS_PER_PHASE = 160;
    localparam int     CORNER_COUNT     = 15;
    // The pipeline is eight stages deep; this covers its latency with room to spare.
    localparam int     SETTLE_CYCLES    = 16;
    localparam int     HOLD_CYCLES      = 64;
    localparam int     HOLD_AT          = 20;
    localparam longint TIMEOUT_NS       = 4_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [FREQ_W-1:0]    FREQ_TOP  = 13'd7936;
    localparam logic [FREQ_W-1:0]    FREQ_ZERO = 13'd0;
    localparam logic [FREQ_W-1:0]    FREQ_FULL = 13'h1FFF;
    localparam logic [PRIME_W-1:0]   PRIME_TOP = 5'd31;

    typedef struct packed {
        logic [FREQ_W-1:0]  mul_a;
        logic [FREQ_W-1:0]  mul_b;
        logic [PRIME_W-1:0] fac_xa;
        logic [PRIME_W-1:0] fac_ya;
        logic [PRIME_W-1:0] fac_xb;
        logic [PRIME_W-1:0] fac_yb;
        logic [MIX_W-1:0]   weight;
    } curve_setting_t;

    typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PATTERN} sink_style_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;    // angle[15:0], phase[31:16]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;    // x_pos[9:0], y_pos[18:10]
    int unsigned             outstanding_points;
    int unsigned             point_errors;
    // Long receiver hold-offs asked by the stimulus and carried out by the sink.
    int unsigned             holds_asked;

    // Corner requests, packed as {phase, angle}: zero and full scale of both fields,
    // the quarter turns, alternating bit patterns and the smallest nonzero steps.
    logic [IN_DATA_W-1:0] corner_requests [CORNER_COUNT] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_4000,
        32'h0000_8000, 32'h0000_C000, 32'h4000_0000, 32'hAAAA_5555, 32'h5555_AAAA,
        32'h0000_0001, 32'h3FFF_0000, 32'hFF00_00FF, 32'h003F_0100, 32'h0001_FFFF
    };

    sinusoid_curve_point_generator #(
        .WIDTH            (WIDTH_DEF),
        .HEIGHT           (HEIGHT_DEF),
        .SINE_TABLE_DEPTH (SINE_DEPTH_DEF)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    curve_point_checker #(
        .WIDTH            (WIDTH_DEF),
        .HEIGHT           (HEIGHT_DEF),
        .SINE_TABLE_DEPTH (SINE_DEPTH_DEF)
    ) u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .outstanding_points (outstanding_points),
        .point_errors       (point_errors)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Register settings per phase. The first few hit the extremes and the out-of-range
    // codes: mix of zero, mix above ten, zero and one as primes, zero and full frequency.
    // Later phases are random, mostly inside the legal ranges.
    function automatic curve_setting_t pick_setting(input int phase_no);
        curve_setting_t     cs;
        logic [PRIME_W-1:0] primes [11];
        primes = '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29, 5'd31};
        case (phase_no)
            1: cs = '{FREQ_TOP, FREQ_TOP, PRIME_TOP, PRIME_TOP, PRIME_TOP, PRIME_TOP, MIX_MAX};
            2: cs = '{FREQ_RST, FREQ_RST, PRIME_RST, PRIME_RST, PRIME_RST, PRIME_RST, MIX_MIN};
            3: cs = '{FREQ_ZERO, FREQ_FULL, 5'd0, 5'd1, 5'd0, 5'd1, 4'd0};
            4: cs = '{FREQ_FULL, 13'd1, 5'd1, PRIME_TOP, 5'd4, 5'd9, 4'd15};
            default:
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    cs = curve_setting_t'({$urandom, $urandom});
                end
                else
                begin
                    cs.mul_a  = FREQ_W'($urandom_range(256, 7936));
                    cs.mul_b  = FREQ_W'($urandom_range(256, 7936));
                    cs.fac_xa = primes[$urandom_range(0, 10)];
                    cs.fac_ya = primes[$urandom_range(0, 10)];
                    cs.fac_xb = primes[$urandom_range(0, 10)];
                    cs.fac_yb = primes[$urandom_range(0, 10)];
                    cs.weight = MIX_W'($urandom_range(1, 10));
                end
                if (phase_no == 5)
                begin
                    cs.weight = MIX_W'($urandom_range(11, 14));
                end
            end
        endcase
        return cs;
    endfunction

    // Writes every register, one per clock. The narrow registers get random upper
    // bits to show that only their own width is kept. The unused index is written last.
    task automatic program_curve(input curve_setting_t cs);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FREQ_M;
        cfg_data  <= cs.mul_a;
        @(posedge clk);
        cfg_index <= CFG_FREQ_N;
        cfg_data  <= cs.mul_b;
        @(posedge clk);
        cfg_index <= CFG_PRIME_I;
        cfg_data  <= {8'($urandom), cs.fac_xa};
        @(posedge clk);
        cfg_index <= CFG_PRIME_J;
        cfg_data  <= {8'($urandom), cs.fac_ya};
        @(posedge clk);
        cfg_index <= CFG_PRIME_K;
        cfg_data  <= {8'($urandom), cs.fac_xb};
        @(posedge clk);
        cfg_index <= CFG_PRIME_L;
        cfg_data  <= {8'($urandom), cs.fac_yb};
        @(posedge clk);
        cfg_index <= CFG_MIX;
        cfg_data  <= {9'($urandom), cs.weight};
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] random_request();
        logic [ANGLE_W-1:0] ang;
        logic [ANGLE_W-1:0] ph;
        ang = ANGLE_W'($urandom);
        ph  = ANGLE_W'($urandom);
        // Now and then pin a field to an end of its range or to a tiny angle.
        case ($urandom_range(0, 11))
            0:       ang = '0;
            1:       ang = '1;
            2:       ph  = '0;
            3:       ph  = '1;
            4:       ang = ANGLE_W'($urandom_range(0, 15));
            default: ;
        endcase
        return {ph, ang};
    endfunction

    // Offers one request and returns just after the edge that accepted it. Ready is
    // looked at on the falling edge, where it is settled for the coming rising edge.
    task automatic send_request(input logic [IN_DATA_W-1:0] req);
        logic taken;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do
        begin
            @(negedge clk);
            taken = (s_axis_tready === 1'b1);
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Stops offering until every predicted point has come back, then lets the
    // pipeline run empty before the registers may change.
    task automatic drain_points();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding_points != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus. Phase zero runs the corner requests on the reset settings; every later
    // phase loads new settings and sends random requests. Every third phase the sender
    // never idles, and there, phase zero apart, the receiver is asked once for a long hold-off
    // so that the pipeline fills and stalls the request side; the other phases send in bursts.
    initial
    begin : stimulus
        int burst_left;
        bit steady;
        int count;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        holds_asked   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++)
        begin
            if (phase_no > 0)
            begin
                program_curve(pick_setting(phase_no));
            end
            steady     = (phase_no % 3 == 0);
            burst_left = 0;
            count      = (phase_no == 0) ? CORNER_COUNT : POINTS_PER_PHASE;
            for (int n = 0; n < count; n++)
            begin
                if (!steady)
                begin
                    if (burst_left == 0)
                    begin
                        s_axis_tvalid <= 1'b0;
                        repeat ($urandom_range(1, 10)) @(posedge clk);
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                end
                if (steady && phase_no > 0 && n == HOLD_AT)
                begin
                    holds_asked <= holds_asked + 1;
                end
                send_request((phase_no == 0) ? corner_requests[n] : random_request());
            end
            drain_points();
        end
        if (point_errors == 0 && outstanding_points == 0)
        begin
            $display("** sinusoid_curve_point_generator: PASSED **");
        end
        else
        begin
            $display("** sinusoid_curve_point_generator: FAILED **");
        end
        $finish;
    end

    // Receiver. It changes its stall style after each run of random length: always ready, light
    // or heavy random stalls, or a rotating bit pattern. A hold-off asked by the
    // stimulus takes precedence and keeps ready low for a long, counted stretch.
    initial
    begin : sink
        int unsigned holds_served;
        int unsigned run_left;
        sink_style_t style;
        logic [7:0]  pattern;
        holds_served  = 0;
        run_left      = 0;
        style         = SINK_OPEN;
        pattern       = '1;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    style    = sink_style_t'($urandom_range(0, 3));
                    run_left = $urandom_range(16, 160);
                    pattern  = 8'($urandom) | 8'h01;
                end
                run_left--;
                case (style)
                    SINK_OPEN:  m_axis_tready <= 1'b1;
                    SINK_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    SINK_HEAVY: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default:
                    begin
                        m_axis_tready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("** sinusoid_curve_point_generator: FAILED **");
        $finish;
    end

endmodule

// ----- sinusoid_curve_point_generator.f -----
design/scpg_pkg.sv
design/sinusoid_curve_point_generator.sv
tb/curve_point_checker.sv
tb/testbench.sv
